@@ rtl/vn_pkg.sv @@
`default_nettype none
package vn_pkg;
    localparam int COMP_W      = 32;
    localparam int SQ_W        = 2 * COMP_W;
    localparam int LEN_W       = 32;
    localparam int QUO_W       = 17;
    localparam int UNIT_W      = 18;
    localparam int SQRT_STAGES = LEN_W;
    localparam int DIV_STAGES  = QUO_W;
    // input reg, squares, sum, root steps, divide steps, output reg
    localparam int PIPE_DEPTH  = 3 + SQRT_STAGES + DIV_STAGES + 1;
    localparam int IN_DATA_W   = 3 * COMP_W;
    localparam int OUT_DATA_W  = 88;
endpackage
`default_nettype wire

@@ rtl/vn_isqrt.sv @@
`default_nettype none
module vn_isqrt
    import vn_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_ce,
    input  wire logic [SQ_W-1:0]  i_radicand,
    output logic      [LEN_W-1:0] o_root
);
    // one root bit per stage, two radicand bits brought down each time
    logic [LEN_W+2:0] r_rem  [SQRT_STAGES];
    logic [LEN_W-1:0] r_root [SQRT_STAGES];
    logic [SQ_W-1:0]  r_rad  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_step
        logic [LEN_W+2:0] w_rem_in;
        logic [LEN_W-1:0] w_root_in;
        logic [SQ_W-1:0]  w_rad_in;
        logic [LEN_W+2:0] w_rem2;
        logic [LEN_W+2:0] w_trial;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_radicand;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rad_in  = r_rad[k-1];
        end

        assign w_rem2  = {w_rem_in[LEN_W:0], w_rad_in[SQ_W-1-2*k -: 2]};
        assign w_trial = {1'b0, w_root_in, 2'b01};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rad[k] <= w_rad_in;
                if (w_rem2 >= w_trial) begin
                    r_rem[k]  <= w_rem2 - w_trial;
                    r_root[k] <= {w_root_in[LEN_W-2:0], 1'b1};
                end else begin
                    r_rem[k]  <= w_rem2;
                    r_root[k] <= {w_root_in[LEN_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_root = r_root[SQRT_STAGES-1];
endmodule
`default_nettype wire

@@ rtl/vn_udiv.sv @@
`default_nettype none
module vn_udiv
    import vn_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_ce,
    input  wire logic [COMP_W-1:0] i_mag,
    input  wire logic [LEN_W-1:0]  i_len,
    output logic      [QUO_W-1:0]  o_quo
);
    // (mag << 16) / len; quotient fits 17 bits, so the partial remainder
    // starts at mag >> 1 and only bit 16 of the dividend is nonzero below it
    logic [LEN_W-1:0]  r_rem [DIV_STAGES];
    logic [LEN_W-1:0]  r_len [DIV_STAGES];
    logic [QUO_W-1:0]  r_quo [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_step
        logic [LEN_W-1:0] w_rem_in;
        logic [LEN_W-1:0] w_len_in;
        logic [QUO_W-1:0] w_quo_in;
        logic             w_bit;
        logic [LEN_W:0]   w_rem2;
        logic [LEN_W:0]   w_diff;

        if (k == 0) begin : g_first
            assign w_rem_in = {1'b0, i_mag[COMP_W-1:1]};
            assign w_len_in = i_len;
            assign w_quo_in = '0;
            assign w_bit    = i_mag[0];
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_len_in = r_len[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_bit    = 1'b0;
        end

        assign w_rem2 = {w_rem_in, w_bit};
        assign w_diff = w_rem2 - {1'b0, w_len_in};

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_len[k] <= w_len_in;
                if (w_rem2 >= {1'b0, w_len_in}) begin
                    r_rem[k] <= w_diff[LEN_W-1:0];
                    r_quo[k] <= {w_quo_in[QUO_W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= w_rem2[LEN_W-1:0];
                    r_quo[k] <= {w_quo_in[QUO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_quo = r_quo[DIV_STAGES-1];
endmodule
`default_nettype wire

@@ rtl/vector3_normalize.sv @@
// Throughput: one vector per cycle unless stalled; a 32-stage square root pipeline and
// three 17-stage divide pipelines each retire one word per cycle.
// The whole pipeline stalls together only while the output word waits.
// Reset (synchronous, active low) clears the valid bits; data is not reset.
`default_nettype none
module vector3_normalize
    import vn_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // comp_x[31:0], comp_y[63:32], comp_z[95:64]
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // unit_x[17:0], unit_y[35:18], unit_z[53:36], length[85:54], zero pad
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata,
    // zero_length
    output logic                       o_m_axis_tuser
);
    logic                  w_ce;
    logic [PIPE_DEPTH-1:0] r_vld;

    logic [2:0][COMP_W-1:0] r_mag0, r_mag1, r_mag2;
    logic [2:0]             r_sg0, r_sg1, r_sg2;
    logic [2:0][SQ_W-1:0]   r_sq;
    logic [SQ_W-1:0]        r_sum;

    logic [2:0][COMP_W-1:0] r_mag_q [SQRT_STAGES];
    logic [2:0]             r_sg_q  [SQRT_STAGES];
    logic [2:0]             r_sg_d  [DIV_STAGES];
    logic [LEN_W-1:0]       r_len_d [DIV_STAGES];

    logic [LEN_W-1:0]       w_root;
    logic [2:0][QUO_W-1:0]  w_quo;
    logic [2:0][UNIT_W-1:0] w_unit;
    logic                   w_zero;

    logic [2:0][UNIT_W-1:0] r_unit;
    logic [LEN_W-1:0]       r_len;
    logic                   r_zero;

    assign w_ce            = ~r_vld[PIPE_DEPTH-1] | i_m_axis_tready;
    assign o_s_axis_tready = w_ce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_ce) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_axis_tvalid};
        end
    end

    // magnitudes and signs, squares and their sum
    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int c = 0; c < 3; c++) begin
                r_sg0[c] <= i_s_axis_tdata[c*COMP_W + COMP_W-1];
                r_mag0[c] <= i_s_axis_tdata[c*COMP_W + COMP_W-1]
                    ? COMP_W'(-i_s_axis_tdata[c*COMP_W +: COMP_W])
                    : i_s_axis_tdata[c*COMP_W +: COMP_W];
            end
            for (int c = 0; c < 3; c++) begin
                r_sq[c] <= SQ_W'(r_mag0[c]) * SQ_W'(r_mag0[c]);
            end
            r_mag1 <= r_mag0;
            r_sg1  <= r_sg0;
            r_sum  <= r_sq[0] + r_sq[1] + r_sq[2];
            r_mag2 <= r_mag1;
            r_sg2  <= r_sg1;
        end
    end

    vn_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_ce       (w_ce),
        .i_radicand (r_sum),
        .o_root     (w_root)
    );

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_mag_q[0] <= r_mag2;
            r_sg_q[0]  <= r_sg2;
            for (int k = 1; k < SQRT_STAGES; k++) begin
                r_mag_q[k] <= r_mag_q[k-1];
                r_sg_q[k]  <= r_sg_q[k-1];
            end
            r_sg_d[0]  <= r_sg_q[SQRT_STAGES-1];
            r_len_d[0] <= w_root;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_sg_d[k]  <= r_sg_d[k-1];
                r_len_d[k] <= r_len_d[k-1];
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_div
        vn_udiv u_udiv (
            .i_clk (i_clk),
            .i_ce  (w_ce),
            .i_mag (r_mag_q[SQRT_STAGES-1][c]),
            .i_len (w_root),
            .o_quo (w_quo[c])
        );
    end

    assign w_zero = (r_len_d[DIV_STAGES-1] == '0);

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            if (w_zero) begin
                w_unit[c] = '0;
            end else if (r_sg_d[DIV_STAGES-1][c]) begin
                w_unit[c] = -UNIT_W'(w_quo[c]);
            end else begin
                w_unit[c] = UNIT_W'(w_quo[c]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_unit <= w_unit;
            r_len  <= r_len_d[DIV_STAGES-1];
            r_zero <= w_zero;
        end
    end

    assign o_m_axis_tvalid = r_vld[PIPE_DEPTH-1];
    assign o_m_axis_tdata  = {(OUT_DATA_W - 3*UNIT_W - LEN_W)'(0), r_len,
                              r_unit[2], r_unit[1], r_unit[0]};
    assign o_m_axis_tuser  = r_zero;

    a_zero_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> (r_len == '0) && (r_unit == '0))
        else $error("zero vector output not cleared");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser |->
            ($signed(r_unit[0]) <= 18'sd65536) && ($signed(r_unit[0]) >= -18'sd65536) &&
            ($signed(r_unit[1]) <= 18'sd65536) && ($signed(r_unit[1]) >= -18'sd65536) &&
            ($signed(r_unit[2]) <= 18'sd65536) && ($signed(r_unit[2]) >= -18'sd65536))
        else $error("unit component out of range");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ce |=> $stable(r_vld) && $stable(r_len) && $stable(r_unit))
        else $error("pipeline moved while stalled");
endmodule
`default_nettype wire

@@ tb/testbench.sv @@
module testbench;
    import vn_pkg::*;

    typedef struct packed {
        logic signed [COMP_W-1:0] z;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] x;
    } vec_t;

    typedef struct {
        logic [UNIT_W-1:0] ux;
        logic [UNIT_W-1:0] uy;
        logic [UNIT_W-1:0] uz;
        logic [LEN_W-1:0]  len;
        logic              zero;
    } unit_vec_t;

    localparam int LIMIT_CYCLES = 400000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic                  o_m_axis_tuser;

    vector3_normalize DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    vec_t      pending_vecs[$];
    unit_vec_t expected_units[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_cycles;
    int        n_errors;
    int        n_checked;
    int        n_zero;
    longint    cycle_count;

    function automatic logic [63:0] isqrt(logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [UNIT_W-1:0] unit_comp(logic signed [COMP_W-1:0] c,
                                                    logic [63:0] len);
        logic [63:0] mag;
        logic [63:0] q;
        mag = c[COMP_W-1] ? 64'(-{32'h0, c}) & 64'hFFFF_FFFF : {32'h0, c};
        q   = (mag << 16) / len;
        if (c[COMP_W-1]) q = -q;
        return q[UNIT_W-1:0];
    endfunction

    function automatic unit_vec_t normalize(vec_t v);
        unit_vec_t r;
        logic [63:0] ax, ay, az, len;
        ax  = v.x[COMP_W-1] ? 64'(-{32'h0, v.x}) & 64'hFFFF_FFFF : {32'h0, v.x};
        ay  = v.y[COMP_W-1] ? 64'(-{32'h0, v.y}) & 64'hFFFF_FFFF : {32'h0, v.y};
        az  = v.z[COMP_W-1] ? 64'(-{32'h0, v.z}) & 64'hFFFF_FFFF : {32'h0, v.z};
        len = isqrt(ax * ax + ay * ay + az * az);
        if (len == 0) begin
            r = '{ux: '0, uy: '0, uz: '0, len: '0, zero: 1'b1};
        end else begin
            r.ux = unit_comp(v.x, len);
            r.uy = unit_comp(v.y, len);
            r.uz = unit_comp(v.z, len);
            r.len = len[LEN_W-1:0];
            r.zero = 1'b0;
        end
        return r;
    endfunction

    // mostly full-range random components, some within 16 bits, some at the extremes, some tiny
    function automatic logic [COMP_W-1:0] rand_comp();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 8) - 4;
            1:       return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            2:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_units.push_back(normalize(vec_t'(i_s_axis_tdata)));
                void'(pending_vecs.pop_front());
            end
            if (pending_vecs.size() > 0
                && (i_s_axis_tvalid && !o_s_axis_tready
                    || $urandom_range(0, 99) >= send_idle_pct)) begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= (i_s_axis_tvalid && !o_s_axis_tready)
                                   ? i_s_axis_tdata : pending_vecs[0];
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure, with a long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles     <= hold_cycles - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= $urandom_range(0, 99) >= recv_idle_pct;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        unit_vec_t exp_u;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_units.size() == 0) begin
                $display("%0t: unexpected word %h user %b", $time, o_m_axis_tdata,
                         o_m_axis_tuser);
                n_errors++;
            end else begin
                exp_u = expected_units.pop_front();
                n_checked++;
                if (exp_u.zero) n_zero++;
                if (o_m_axis_tdata[17:0] !== exp_u.ux) begin
                    $display("%0t: unit_x exp %h got %h", $time, exp_u.ux,
                             o_m_axis_tdata[17:0]);
                    n_errors++;
                end
                if (o_m_axis_tdata[35:18] !== exp_u.uy) begin
                    $display("%0t: unit_y exp %h got %h", $time, exp_u.uy,
                             o_m_axis_tdata[35:18]);
                    n_errors++;
                end
                if (o_m_axis_tdata[53:36] !== exp_u.uz) begin
                    $display("%0t: unit_z exp %h got %h", $time, exp_u.uz,
                             o_m_axis_tdata[53:36]);
                    n_errors++;
                end
                if (o_m_axis_tdata[85:54] !== exp_u.len) begin
                    $display("%0t: length exp %h got %h", $time, exp_u.len,
                             o_m_axis_tdata[85:54]);
                    n_errors++;
                end
                if (o_m_axis_tuser !== exp_u.zero) begin
                    $display("%0t: zero_length exp %b got %b", $time, exp_u.zero,
                             o_m_axis_tuser);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_vecs.size() != 0 || expected_units.size() != 0
               || i_s_axis_tvalid)
            @(posedge i_clk);
    endtask

    task automatic add_vec(logic [COMP_W-1:0] x, logic [COMP_W-1:0] y,
                           logic [COMP_W-1:0] z);
        pending_vecs.push_back('{x: x, y: y, z: z});
    endtask

    task automatic add_random(int count);
        for (int i = 0; i < count; i++) add_vec(rand_comp(), rand_comp(), rand_comp());
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b0;
        send_idle_pct   = 16;
        recv_idle_pct   = 58;
        hold_cycles     = 0;
        n_errors        = 0;
        n_checked       = 0;
        n_zero          = 0;
        cycle_count     = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero vector, extremes, axes, signs, small values
        add_vec(0, 0, 0);
        add_vec(32'h8000_0000, 0, 0);
        add_vec(0, 32'h8000_0000, 0);
        add_vec(0, 0, 32'h8000_0000);
        add_vec(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_vec(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_vec(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_vec(1, 0, 0);
        add_vec(0, 32'hFFFF_FFFF, 0);
        add_vec(0, 0, 1);
        add_vec(1, 1, 1);
        add_vec(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_vec(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
        add_vec(32'h0003_0000, 32'h0004_0000, 0);
        add_vec(32'hFFFD_0000, 0, 32'hFFFC_0000);
        add_vec(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000);
        add_vec(32'h0000_FFFF, 32'h8000_0001, 32'h0000_0002);
        add_vec(0, 0, 0);
        add_random(650);
        wait_drained();

        // long receiver stall: fill the pipe and back up the input
        hold_cycles = 200;
        add_random(150);
        wait_drained();

        send_idle_pct = 58;
        recv_idle_pct = 16;
        add_random(600);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(600);
        wait_drained();

        repeat (PIPE_DEPTH + 20) @(posedge i_clk);
        $display("%0d vectors checked, %0d zero vectors; extremes, random data,",
                 n_checked, n_zero);
        $display("two idle mixes, a long output stall and back-to-back traffic");
        if (n_errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end
endmodule
